/* rtl/core/ftmd_pkg.sv */
// Shared types and constants of the FTP transfer-mode decoder.
package ftmd_pkg;

  localparam logic [1:0] MODE_STREAM = 2'd0;
  localparam logic [1:0] MODE_BLOCK  = 2'd1;
  localparam logic [1:0] MODE_COMP   = 2'd2;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_FILL = 2'd1;

  localparam logic [1:0] FUNC_DATA = 2'd0;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_BLK_HDR      = 4'd1;
  localparam logic [3:0] ST_BLK_PAYLOAD  = 4'd2;
  localparam logic [3:0] ST_BLK_NO_EOF   = 4'd3;
  localparam logic [3:0] ST_BLK_AFTER    = 4'd4;
  localparam logic [3:0] ST_CMP_ESC      = 4'd5;
  localparam logic [3:0] ST_CMP_LITERAL  = 4'd6;
  localparam logic [3:0] ST_CMP_REPEAT   = 4'd7;
  localparam logic [3:0] ST_CMP_FILLER   = 4'd8;
  localparam logic [3:0] ST_CMP_NO_EOF   = 4'd9;
  localparam logic [3:0] ST_CMP_AFTER    = 4'd10;

  localparam logic [7:0] BYTE_ESCAPE = 8'hff;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  localparam logic [1:0] STR_LITERAL = 2'b00;
  localparam logic [1:0] STR_REPEAT  = 2'b10;

  // One decoded request: data byte emitted count times, then an optional status.
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] count;
    logic       stat_en;
    logic [3:0] status;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

/* rtl/core/ftmd_front.sv */
// Front end: configuration registers and per-byte stream decoding into requests.
module ftmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [7:0]        in_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output ftmd_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_ONE  = 4'b0010,
    PH_TWO  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  logic [1:0]  mode;
  logic        fill;
  phase_t      phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  count_high, count_high_next;
  logic        block_is_final, block_is_final_next;
  logic        eof_seen, eof_seen_next;
  logic [3:0]  error_code, error_code_next;
  logic        is_data, is_end, accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_data   = !func[1];
  assign is_end    = func != ftmd_pkg::FUNC_DATA;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ftmd_pkg::MODE_STREAM;
      fill <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == ftmd_pkg::CFG_MODE) mode <= cfg_data[1:0];
      else if (cfg_index == ftmd_pkg::CFG_FILL) fill <= cfg_data[0];
    end
  end

  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    count_high_next     = count_high;
    block_is_final_next = block_is_final;
    eof_seen_next       = eof_seen;
    error_code_next     = error_code;
    cmd.data            = in_byte;
    cmd.count           = 6'd0;
    cmd.stat_en         = 1'b0;
    cmd.status          = ftmd_pkg::ST_OK;

    if (is_data && error_code == ftmd_pkg::ST_OK) begin
      unique case (mode)
        ftmd_pkg::MODE_BLOCK: begin
          if (eof_seen) begin
            error_code_next = ftmd_pkg::ST_BLK_AFTER;
          end else begin
            unique case (phase)
              PH_ONE: begin
                count_high_next = in_byte;
                phase_next      = PH_TWO;
              end
              PH_TWO: begin
                remaining_next = {count_high, in_byte};
                phase_next     = PH_BODY;
                if (remaining_next == 16'd0) begin
                  phase_next = PH_HEAD;
                  if (block_is_final) eof_seen_next = 1'b1;
                end
              end
              PH_BODY: begin
                cmd.count      = 6'd1;
                remaining_next = remaining - 16'd1;
                if (remaining_next == 16'd0) begin
                  phase_next = PH_HEAD;
                  if (block_is_final) eof_seen_next = 1'b1;
                end
              end
              default: begin
                block_is_final_next = in_byte[6];
                phase_next          = PH_ONE;
              end
            endcase
          end
        end
        ftmd_pkg::MODE_COMP: begin
          if (eof_seen) begin
            error_code_next = ftmd_pkg::ST_CMP_AFTER;
          end else begin
            unique case (phase)
              PH_ONE: begin
                phase_next = PH_HEAD;
                if (in_byte[6]) eof_seen_next = 1'b1;
              end
              PH_TWO: begin
                cmd.count      = 6'd1;
                remaining_next = remaining - 16'd1;
                if (remaining_next == 16'd0) phase_next = PH_HEAD;
              end
              PH_BODY: begin
                cmd.count      = remaining[5:0];
                remaining_next = 16'd0;
                phase_next     = PH_HEAD;
              end
              default: begin
                phase_next = PH_HEAD;
                if (in_byte == ftmd_pkg::BYTE_ESCAPE) begin
                  phase_next = PH_ONE;
                end else if (in_byte[7:6] == ftmd_pkg::STR_LITERAL) begin
                  if (in_byte[5:0] == 6'd0) begin
                    error_code_next = ftmd_pkg::ST_CMP_LITERAL;
                  end else begin
                    remaining_next = {10'd0, in_byte[5:0]};
                    phase_next     = PH_TWO;
                  end
                end else if (in_byte[7:6] == ftmd_pkg::STR_REPEAT) begin
                  if (in_byte[5:0] == 6'd0) begin
                    error_code_next = ftmd_pkg::ST_CMP_REPEAT;
                  end else begin
                    remaining_next = {10'd0, in_byte[5:0]};
                    phase_next     = PH_BODY;
                  end
                end else begin
                  if (in_byte[5:0] == 6'd0) begin
                    error_code_next = ftmd_pkg::ST_CMP_FILLER;
                  end else begin
                    cmd.count = in_byte[5:0];
                    cmd.data  = fill ? ftmd_pkg::BYTE_SPACE : ftmd_pkg::BYTE_ZERO;
                  end
                end
              end
            endcase
          end
        end
        default: cmd.count = 6'd1;
      endcase
    end

    if (is_end) begin
      cmd.stat_en = 1'b1;
      if (error_code_next != ftmd_pkg::ST_OK) begin
        cmd.status = error_code_next;
      end else if (mode == ftmd_pkg::MODE_BLOCK && !eof_seen_next) begin
        if (phase_next == PH_ONE || phase_next == PH_TWO) cmd.status = ftmd_pkg::ST_BLK_HDR;
        else if (phase_next == PH_BODY) cmd.status = ftmd_pkg::ST_BLK_PAYLOAD;
        else cmd.status = ftmd_pkg::ST_BLK_NO_EOF;
      end else if (mode == ftmd_pkg::MODE_COMP && !eof_seen_next) begin
        if (phase_next == PH_ONE) cmd.status = ftmd_pkg::ST_CMP_ESC;
        else if (phase_next == PH_TWO) cmd.status = ftmd_pkg::ST_CMP_LITERAL;
        else if (phase_next == PH_BODY) cmd.status = ftmd_pkg::ST_CMP_REPEAT;
        else cmd.status = ftmd_pkg::ST_CMP_NO_EOF;
      end
      phase_next          = PH_HEAD;
      remaining_next      = 16'd0;
      count_high_next     = 8'd0;
      block_is_final_next = 1'b0;
      eof_seen_next       = 1'b0;
      error_code_next     = ftmd_pkg::ST_OK;
    end
  end

  assign q_push = accept && (cmd.count != 6'd0 || cmd.stat_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD;
      remaining      <= 16'd0;
      count_high     <= 8'd0;
      block_is_final <= 1'b0;
      eof_seen       <= 1'b0;
      error_code     <= ftmd_pkg::ST_OK;
    end else if (accept) begin
      phase          <= phase_next;
      remaining      <= remaining_next;
      count_high     <= count_high_next;
      block_is_final <= block_is_final_next;
      eof_seen       <= eof_seen_next;
      error_code     <= error_code_next;
    end
  end

endmodule

/* rtl/core/ftmd_queue.sv */
// Request queue between the decoding front end and the output back end.
module ftmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ftmd_pkg::cmd_t    wr_cmd,
  input  logic              push,
  output ftmd_pkg::q_wr_t   wr_st,
  input  logic              pop,
  output ftmd_pkg::q_rd_t   rd_st,
  output ftmd_pkg::cmd_t    rd_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ftmd_pkg::cmd_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   used;

  assign wr_st.push  = push;
  assign wr_st.full  = used == FULL_CNT;
  assign rd_st.pop   = pop;
  assign rd_st.empty = used == '0;
  assign rd_cmd      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) used <= used + CW'(1);
      else if (pop && !push) used <= used - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !wr_st.full || pop)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !rd_st.empty)
    else $error("request popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) used <= FULL_CNT)
    else $error("queue occupancy beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> used == $past(used) + CW'(1))
    else $error("queue occupancy not advanced on push");

endmodule

/* rtl/core/ftmd_back.sv */
// Back end: expands requests into output results, one per cycle while out_ready is high.
module ftmd_back (
  input  logic              clk,
  input  logic              rst,
  input  ftmd_pkg::q_rd_t   rd_st,
  input  ftmd_pkg::cmd_t    rd_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [7:0]        out_byte,
  output logic [3:0]        status,
  output logic              last
);

  logic       busy;
  logic [5:0] rem;
  logic       stat_pend;
  logic [7:0] data;
  logic [3:0] stat;
  logic       fire, done;

  assign out_valid = busy;
  assign kind      = rem == 6'd0;
  assign out_byte  = kind ? 8'd0 : data;
  assign status    = kind ? stat : ftmd_pkg::ST_OK;
  assign last      = kind || (rem == 6'd1 && !stat_pend);
  assign fire      = busy && out_ready;
  assign done      = fire && last;
  assign pop       = !rd_st.empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem       <= rd_cmd.count;
      stat_pend <= rd_cmd.stat_en;
      data      <= rd_cmd.data;
      stat      <= rd_cmd.status;
    end else if (fire && !kind) begin
      rem <= rem - 6'd1;
    end
  end

  a_status_pending: assert property (@(posedge clk) disable iff (rst)
      busy && rem == 6'd0 |-> stat_pend)
    else $error("empty request held without status");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
      pop && busy |-> done)
    else $error("request loaded over one still in progress");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
      busy && !out_ready |=> busy && $stable(rem))
    else $error("stalled result changed");

endmodule

/* rtl/core/ftp_transfer_mode_decoder_unit.sv */
// Top level of the FTP transfer-mode decoder (stream, block and compressed modes).
//
//  channel  signals                                     direction
//  in       in_valid/in_ready, func, in_byte             request in
//  out      out_valid/out_ready, kind, out_byte,         result out
//           status, last
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     register write in
//
// One encoded byte per cycle enters the front end; a byte that yields results
// becomes one queued request, header and control bytes queue nothing unless they end the stream.
// The back end emits one result per cycle while out_ready is high and work is queued:
// a repeated or filler string of n bytes holds the back end until all n bytes are out,
// and the front stalls once the QUEUE_DEPTH queue fills. Reset clears stream state,
// queue and output; configuration writes are always taken (cfg_ready held high).
module ftp_transfer_mode_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [3:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  ftmd_pkg::cmd_t  wr_cmd, rd_cmd;
  ftmd_pkg::q_wr_t wr_st;
  ftmd_pkg::q_rd_t rd_st;
  logic            push, pop;

  ftmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (wr_st.full),
    .q_push    (push),
    .cmd       (wr_cmd)
  );

  ftmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_cmd (wr_cmd),
    .push   (push),
    .wr_st  (wr_st),
    .pop    (pop),
    .rd_st  (rd_st),
    .rd_cmd (rd_cmd)
  );

  ftmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_st     (rd_st),
    .rd_cmd    (rd_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the FTP transfer-mode decoder: random streams against a built-in predictor.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FUNC_LAST    = 2'd1;
  localparam logic [1:0] FUNC_END     = 2'd2;
  localparam logic [1:0] FUNC_END_ALT = 2'd3;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [1:0] CFG_SPARE2   = 2'd2;
  localparam logic [1:0] CFG_SPARE3   = 2'd3;
  localparam logic [1:0] STR_FILLER   = 2'b11;
  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;
  localparam int         EOF_BIT      = 6;
  localparam logic [2:0] DEC_HEAD     = 3'd0;
  localparam logic [2:0] DEC_ONE      = 3'd1;
  localparam logic [2:0] DEC_TWO      = 3'd2;
  localparam logic [2:0] DEC_BODY     = 3'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       drain;
  } byte_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] status;
    logic       last;
  } result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] func;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  byte_req_t  pending_reqs[$];
  result_t    expected_results[$];
  logic [7:0] stream_bytes[$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         mismatches;
  int         reqs_queued;
  int         streams_built;

  // decoder state as predicted
  logic [1:0]  cfg_mode_q;
  logic        cfg_fill_q;
  logic [2:0]  dec_phase;
  logic [15:0] dec_left;
  logic [7:0]  dec_count_hi;
  logic        dec_final_blk;
  logic        dec_eof;
  logic [3:0]  dec_err;

  ftp_transfer_mode_decoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .out_byte(out_byte),
    .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic void clear_stream_state();
    dec_phase     = DEC_HEAD;
    dec_left      = 16'd0;
    dec_count_hi  = 8'd0;
    dec_final_blk = 1'b0;
    dec_eof       = 1'b0;
    dec_err       = ftmd_pkg::ST_OK;
  endfunction

  function automatic void emit_result(logic k, logic [7:0] d, logic [3:0] s);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.last   = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic void latch_error(logic [3:0] code);
    if (dec_err == ftmd_pkg::ST_OK) dec_err = code;
  endfunction

  function automatic void decode_block_byte(logic [7:0] b);
    if (dec_eof) begin
      latch_error(ftmd_pkg::ST_BLK_AFTER);
      return;
    end
    case (dec_phase)
      DEC_ONE: begin
        dec_count_hi = b;
        dec_phase = DEC_TWO;
      end
      DEC_TWO: begin
        dec_left = {dec_count_hi, b};
        dec_phase = DEC_BODY;
        if (dec_left == 16'd0) begin
          dec_phase = DEC_HEAD;
          if (dec_final_blk) dec_eof = 1'b1;
        end
      end
      DEC_BODY: begin
        emit_result(KIND_BYTE, b, ftmd_pkg::ST_OK);
        dec_left = dec_left - 16'd1;
        if (dec_left == 16'd0) begin
          dec_phase = DEC_HEAD;
          if (dec_final_blk) dec_eof = 1'b1;
        end
      end
      default: begin
        dec_final_blk = b[EOF_BIT];
        dec_phase = DEC_ONE;
      end
    endcase
  endfunction

  function automatic void decode_comp_byte(logic [7:0] b);
    logic [5:0] cnt;
    if (dec_eof) begin
      latch_error(ftmd_pkg::ST_CMP_AFTER);
      return;
    end
    case (dec_phase)
      DEC_ONE: begin
        dec_phase = DEC_HEAD;
        if (b[EOF_BIT]) dec_eof = 1'b1;
      end
      DEC_TWO: begin
        emit_result(KIND_BYTE, b, ftmd_pkg::ST_OK);
        dec_left = dec_left - 16'd1;
        if (dec_left == 16'd0) dec_phase = DEC_HEAD;
      end
      DEC_BODY: begin
        cnt = dec_left[5:0];
        for (int i = 0; i < cnt; i++) emit_result(KIND_BYTE, b, ftmd_pkg::ST_OK);
        dec_left = 16'd0;
        dec_phase = DEC_HEAD;
      end
      default: begin
        dec_phase = DEC_HEAD;
        cnt = b[5:0];
        if (b == ftmd_pkg::BYTE_ESCAPE) begin
          dec_phase = DEC_ONE;
        end else if (b[7:6] == ftmd_pkg::STR_LITERAL) begin
          if (cnt == 6'd0) latch_error(ftmd_pkg::ST_CMP_LITERAL);
          else begin
            dec_left = {10'd0, cnt};
            dec_phase = DEC_TWO;
          end
        end else if (b[7:6] == ftmd_pkg::STR_REPEAT) begin
          if (cnt == 6'd0) latch_error(ftmd_pkg::ST_CMP_REPEAT);
          else begin
            dec_left = {10'd0, cnt};
            dec_phase = DEC_BODY;
          end
        end else begin
          if (cnt == 6'd0) latch_error(ftmd_pkg::ST_CMP_FILLER);
          else for (int i = 0; i < cnt; i++)
            emit_result(KIND_BYTE, cfg_fill_q ? ftmd_pkg::BYTE_SPACE : ftmd_pkg::BYTE_ZERO,
                        ftmd_pkg::ST_OK);
        end
      end
    endcase
  endfunction

  function automatic logic [3:0] closing_status();
    if (dec_err != ftmd_pkg::ST_OK) return dec_err;
    if (cfg_mode_q == ftmd_pkg::MODE_BLOCK) begin
      if (dec_eof) return ftmd_pkg::ST_OK;
      if (dec_phase == DEC_ONE || dec_phase == DEC_TWO) return ftmd_pkg::ST_BLK_HDR;
      if (dec_phase == DEC_BODY) return ftmd_pkg::ST_BLK_PAYLOAD;
      return ftmd_pkg::ST_BLK_NO_EOF;
    end
    if (cfg_mode_q == ftmd_pkg::MODE_COMP) begin
      if (dec_eof) return ftmd_pkg::ST_OK;
      if (dec_phase == DEC_ONE) return ftmd_pkg::ST_CMP_ESC;
      if (dec_phase == DEC_TWO) return ftmd_pkg::ST_CMP_LITERAL;
      if (dec_phase == DEC_BODY) return ftmd_pkg::ST_CMP_REPEAT;
      return ftmd_pkg::ST_CMP_NO_EOF;
    end
    return ftmd_pkg::ST_OK;
  endfunction

  function automatic void predict_request(logic [1:0] f, logic [7:0] b);
    int      base;
    int      idx;
    result_t r;
    base = expected_results.size();
    if (f != FUNC_END && f != FUNC_END_ALT && dec_err == ftmd_pkg::ST_OK) begin
      if (cfg_mode_q == ftmd_pkg::MODE_BLOCK) decode_block_byte(b);
      else if (cfg_mode_q == ftmd_pkg::MODE_COMP) decode_comp_byte(b);
      else emit_result(KIND_BYTE, b, ftmd_pkg::ST_OK);
    end
    if (f != ftmd_pkg::FUNC_DATA) begin
      emit_result(KIND_STATUS, ftmd_pkg::BYTE_ZERO, closing_status());
      clear_stream_state();
    end
    if (expected_results.size() > base) begin
      idx = expected_results.size() - 1;
      r = expected_results[idx];
      r.last = 1'b1;
      expected_results[idx] = r;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    byte_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      func     <= ftmd_pkg::FUNC_DATA;
      in_byte  <= 8'd0;
    end else begin
      if (in_valid && in_ready) predict_request(func, in_byte);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          func     <= req.func;
          in_byte  <= req.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d out_byte %0h status %0d last %0d",
                 kind, out_byte, status, last);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, kind);
            mismatches++;
          end
          if (out_byte !== exp_r.data) begin
            $error("out_byte: expected %0h, got %0h", exp_r.data, out_byte);
            mismatches++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            mismatches++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, last);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_req(input logic [1:0] f, input logic [7:0] b, input logic drain);
    byte_req_t req;
    req.func  = f;
    req.data  = b;
    req.drain = drain;
    pending_reqs.insert(pending_reqs.size(), req);
    reqs_queued++;
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ftmd_pkg::CFG_MODE: cfg_mode_q = val[1:0];
      ftmd_pkg::CFG_FILL: cfg_fill_q = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // builds one encoded stream for mode m, mostly well formed
  task automatic build_stream(input logic [1:0] m);
    int         style;
    int         nb;
    int         cnt;
    int         pos;
    logic [7:0] b;
    stream_bytes.delete();
    style = $urandom_range(9);
    if (m == ftmd_pkg::MODE_BLOCK) begin
      nb = $urandom_range(1, 3);
      for (int k = 0; k < nb; k++) begin
        b = 8'($urandom);
        b[EOF_BIT] = (k == nb - 1);
        add_byte(b);
        cnt = ($urandom_range(7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        add_byte(8'(cnt >> 8));
        add_byte(8'(cnt));
        for (int j = 0; j < cnt; j++) add_byte(8'($urandom));
      end
    end else if (m == ftmd_pkg::MODE_COMP) begin
      nb = $urandom_range(1, 5);
      for (int k = 0; k < nb; k++) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
        case ($urandom_range(3))
          0: begin
            add_byte({ftmd_pkg::STR_LITERAL, 6'(cnt)});
            for (int j = 0; j < cnt; j++) add_byte(8'($urandom));
          end
          1: begin
            add_byte({ftmd_pkg::STR_REPEAT, 6'(cnt)});
            add_byte(8'($urandom));
          end
          2: add_byte({STR_FILLER, 6'(cnt)});
          default: begin
            b = 8'($urandom);
            b[EOF_BIT] = 1'b0;
            add_byte(ftmd_pkg::BYTE_ESCAPE);
            add_byte(b);
          end
        endcase
      end
      b = 8'($urandom);
      b[EOF_BIT] = 1'b1;
      add_byte(ftmd_pkg::BYTE_ESCAPE);
      add_byte(b);
    end else begin
      nb = $urandom_range(1, 8);
      for (int k = 0; k < nb; k++) add_byte(8'($urandom));
    end

    if (style == 0) begin
      stream_bytes.delete();
      nb = $urandom_range(1, 10);
      for (int k = 0; k < nb; k++) add_byte(8'($urandom));
    end else if (style == 1) begin
      case ($urandom_range(2))
        0: repeat ($urandom_range(1, stream_bytes.size())) void'(stream_bytes.pop_back());
        1: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        default: begin
          pos = $urandom_range(stream_bytes.size() - 1);
          stream_bytes[pos] = $urandom_range(1) ? 8'($urandom) : {2'($urandom), 6'd0};
        end
      endcase
    end

    streams_built++;
    for (int i = 0; i < stream_bytes.size(); i++)
      add_req((i == stream_bytes.size() - 1 && style[0]) ? FUNC_LAST : ftmd_pkg::FUNC_DATA,
              stream_bytes[i], i == 0 && streams_built % 15 == 0);
    if (stream_bytes.size() == 0 || !style[0])
      add_req(($urandom_range(7) == 0) ? FUNC_END_ALT : FUNC_END, 8'($urandom),
              stream_bytes.size() == 0 && streams_built % 15 == 0);
  endtask

  initial begin
    int         r;
    int         goal;
    logic [1:0] m;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = ftmd_pkg::CFG_MODE;
    cfg_data  = 8'd0;
    mismatches    = 0;
    reqs_queued   = 0;
    streams_built = 0;
    send_idle_pct = 19;
    recv_idle_pct = 73;
    cfg_mode_q    = ftmd_pkg::MODE_STREAM;
    cfg_fill_q    = 1'b0;
    clear_stream_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // stream passthrough, spare register indexes, unused end code
    write_reg(ftmd_pkg::CFG_MODE, {6'h3f, ftmd_pkg::MODE_STREAM});
    write_reg(ftmd_pkg::CFG_FILL, 8'hfe);
    write_reg(CFG_SPARE2, 8'hff);
    write_reg(CFG_SPARE3, 8'h00);
    add_req(ftmd_pkg::FUNC_DATA, 8'hff, 1'b0);
    add_req(FUNC_END_ALT, 8'h00, 1'b0);

    // zero-length block, then final block of one byte
    settle();
    write_reg(ftmd_pkg::CFG_MODE, {6'h00, ftmd_pkg::MODE_BLOCK});
    add_req(ftmd_pkg::FUNC_DATA, 8'h00, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h00, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h00, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h40, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h00, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h01, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'ha5, 1'b0);
    add_req(FUNC_END, 8'hff, 1'b0);

    // every string kind, escape with and without EOF, data after EOF
    settle();
    write_reg(ftmd_pkg::CFG_MODE, {6'h15, ftmd_pkg::MODE_COMP});
    write_reg(ftmd_pkg::CFG_FILL, 8'h01);
    add_req(ftmd_pkg::FUNC_DATA, {ftmd_pkg::STR_LITERAL, 6'd2}, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h61, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h62, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, {ftmd_pkg::STR_REPEAT, 6'd63}, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h7e, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, {STR_FILLER, 6'd3}, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, ftmd_pkg::BYTE_ESCAPE, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'hbf, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, ftmd_pkg::BYTE_ESCAPE, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h40, 1'b0);
    add_req(FUNC_LAST, 8'h01, 1'b0);
    // zero-count repeat latches an error, the next byte is dropped
    add_req(ftmd_pkg::FUNC_DATA, {ftmd_pkg::STR_REPEAT, 6'd0}, 1'b0);
    add_req(FUNC_LAST, {ftmd_pkg::STR_LITERAL, 6'd1}, 1'b0);

    // block header read with its payload left pending, then compressed mode takes it as a repeat
    settle();
    write_reg(ftmd_pkg::CFG_MODE, {6'h00, ftmd_pkg::MODE_BLOCK});
    add_req(ftmd_pkg::FUNC_DATA, 8'h00, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h01, 1'b0);
    add_req(ftmd_pkg::FUNC_DATA, 8'h05, 1'b0);
    settle();
    write_reg(ftmd_pkg::CFG_MODE, {6'h2a, ftmd_pkg::MODE_COMP});
    add_req(ftmd_pkg::FUNC_DATA, 8'h33, 1'b1);
    add_req(FUNC_END, 8'h00, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 19 : 0;
      goal = reqs_queued + 90;
      while (reqs_queued < goal) begin
        settle();
        r = $urandom_range(9);
        m = (r < 4) ? ftmd_pkg::MODE_BLOCK : (r < 8) ? ftmd_pkg::MODE_COMP :
            (r == 8) ? ftmd_pkg::MODE_STREAM : MODE_SPARE;
        write_reg(ftmd_pkg::CFG_MODE, {6'($urandom), m});
        write_reg(ftmd_pkg::CFG_FILL, 8'($urandom));
        repeat ($urandom_range(1, 4)) build_stream(m);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* ftp_transfer_mode_decoder_unit.f */
rtl/core/ftmd_pkg.sv
rtl/core/ftmd_front.sv
rtl/core/ftmd_queue.sv
rtl/core/ftmd_back.sv
rtl/core/ftp_transfer_mode_decoder_unit.sv
sim/testbench.sv
